// ----- sv/rtps_pkg.sv -----
`timescale 1ns / 1ps
package rtps_pkg;

  localparam int unsigned NumMetrics = 4;
  localparam int unsigned MetricW    = 25;
  localparam int unsigned DivW       = 48;
  localparam int unsigned DenW       = 32;
  localparam int unsigned MulAW      = 33;
  localparam int unsigned MulBW      = 15;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 72;
  localparam int unsigned OutDataW   = 136;

  localparam logic signed [MetricW-1:0] MetricMax = 25'sd16777215;
  localparam logic signed [MetricW-1:0] MetricMin = -25'sd32768;

  localparam logic [MulBW-1:0] BitsPerByte = 15'd8;
  localparam logic [MulBW-1:0] MsPerS      = 15'd1000;
  localparam logic [MulBW-1:0] LossScaleQ8 = 15'd25600;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAYLOAD_TYPE = 2'd0,
    REG_DROPOUT_THR  = 2'd1,
    REG_INTERVAL     = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MET_BIT_RATE    = 2'd0,
    MET_PACKET_RATE = 2'd1,
    MET_LOSS        = 2'd2,
    MET_FRAME_RATE  = 2'd3
  } metric_e;

  typedef struct packed {
    logic [31:0]               dropout_count;
    logic signed [MetricW-1:0] average;
    logic signed [MetricW-1:0] maximum;
    logic signed [MetricW-1:0] minimum;
    logic signed [MetricW-1:0] latest;
  } result_t;

  // magnitude and sign to a clamped metric value
  function automatic logic signed [MetricW-1:0] clamp_metric(
    input logic [DivW-1:0] mag,
    input logic            neg
  );
    logic signed [MetricW-1:0] res;
    if (neg) begin
      if (mag > DivW'(32768)) res = MetricMin;
      else res = -$signed(mag[MetricW-1:0]);
    end else begin
      if (mag > DivW'(16777215)) res = MetricMax;
      else res = $signed(mag[MetricW-1:0]);
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] x);
    return (x == 32'hffff_ffff) ? x : x + 32'd1;
  endfunction

endpackage

// ----- sv/rtp_receive_statistics.sv -----
`timescale 1ns / 1ps
// channel  | dir | handshake          | payload
// s_axis   | in  | tvalid/tready      | tdata: type_byte, seq_number, packet_length, arrival_ms
// m_axis   | out | tvalid/tready      | tdata: latest..dropout_count, tuser: metric, tlast: last
// cfg      | in  | cfg_we_i           | cfg_index_i, cfg_data_i
// a packet that does not close the interval only updates the counters.
// a closing packet first computes the four rates, then per metric walks the
// window (read, then accumulate per entry), divides for the average and outputs.
// all divisions share one 48-step restoring divider; the window sits in one two-port memory.
// s_axis_tready is low while results are built or wait on m_axis_tready.
// rst_ni clears all counters and the window fill at once; no clearing pass.
module rtp_receive_statistics import rtps_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // type_byte[7:0], seq_number[23:8], packet_length[39:24], arrival_ms[71:40]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // latest[24:0], minimum[49:25], maximum[74:50], average[99:75],
  // dropout_count[131:100], zero[135:132]
  output logic [OutDataW-1:0] m_axis_tdata,
  // metric[1:0]
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned MemDepth = NumMetrics * WINDOW_DEPTH;
  localparam int unsigned AddrW = $clog2(MemDepth);
  localparam int unsigned SumW = MetricW + FillW;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_SAT  = 8'b0000_1000,
    ST_WALK = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_AVG  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [6:0]  pt_q;
  logic [15:0] thr_q;
  logic [15:0] interval_q;

  logic [31:0] start_ms_q, prev_ms_q, byte_q, pkt_q, frame_q, drop_q;
  logic [15:0] start_seq_q;
  logic [SlotW-1:0] slot_q;
  logic [FillW-1:0] fill_q;

  logic [31:0] elapsed_q;
  logic [16:0] expected_q;
  logic [1:0]  m_q;
  logic        avg_phase_q;
  logic        neg_q;
  logic [DivW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q;
  logic [5:0]      cnt_q;
  logic signed [MetricW-1:0] val_q [NumMetrics];
  logic [FillW-1:0] idx_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [MetricW-1:0] lo_q, hi_q;
  result_t out_q;
  logic [1:0] metric_q;
  logic    last_q;

  logic [MetricW-1:0] mem [MemDepth];
  logic [MetricW-1:0] rd_data_q;

  // packet update
  logic [7:0]  in_tb;
  logic [15:0] in_seq, in_len;
  logic [31:0] in_now;
  logic        accept, first;
  logic [31:0] start_d, prev_eff, gap, elapsed_d, byte_d;
  logic [32:0] byte_sum;
  logic [15:0] start_seq_d;

  assign in_tb  = s_axis_tdata[7:0];
  assign in_seq = s_axis_tdata[23:8];
  assign in_len = s_axis_tdata[39:24];
  assign in_now = s_axis_tdata[71:40];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready && (in_tb[6:0] == pt_q);
  assign first = (pkt_q == 32'd0);
  assign start_d = first ? in_now : start_ms_q;
  assign start_seq_d = first ? in_seq : start_seq_q;
  assign prev_eff = (first && fill_q == '0) ? in_now : prev_ms_q;
  assign gap = in_now - prev_eff;
  assign elapsed_d = in_now - start_d;
  assign byte_sum = {1'b0, byte_q} + {17'd0, in_len};
  assign byte_d = byte_sum[32] ? 32'hffff_ffff : byte_sum[31:0];

  // operand select for the rate multiply
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [DenW-1:0]  den_sel;
  logic             neg_sel;
  logic signed [MulAW:0] diff;

  assign diff = $signed({17'd0, expected_q}) - $signed({2'd0, pkt_q});

  always_comb begin
    mul_a = {1'b0, byte_q};
    mul_b = BitsPerByte;
    den_sel = elapsed_q;
    neg_sel = 1'b0;
    unique case (metric_e'(m_q))
      MET_BIT_RATE: begin
        mul_a = {1'b0, byte_q};
        mul_b = BitsPerByte;
      end
      MET_PACKET_RATE: begin
        mul_a = MulAW'(expected_q);
        mul_b = MsPerS;
      end
      MET_LOSS: begin
        neg_sel = diff[MulAW];
        mul_a = neg_sel ? MulAW'(-diff) : MulAW'(diff);
        mul_b = LossScaleQ8;
        den_sel = DenW'(expected_q);
      end
      MET_FRAME_RATE: begin
        mul_a = {1'b0, frame_q};
        mul_b = MsPerS;
      end
      default: ;
    endcase
  end

  // divider step
  logic [DenW:0] rem_sh, rem_sub;
  logic          q_bit;
  assign rem_sh = {rem_q[DenW-1:0], num_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_bit = (rem_sh >= {1'b0, den_q});

  logic signed [MetricW-1:0] sat_val;
  assign sat_val = clamp_metric(num_q, neg_q);

  logic signed [MetricW-1:0] rd_val;
  assign rd_val = $signed(rd_data_q);

  logic [SumW-1:0] sum_mag;
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  logic mem_we;
  logic [AddrW-1:0] waddr, raddr;
  assign mem_we = (state_q == ST_SAT) && !avg_phase_q;
  assign waddr = AddrW'(m_q) * AddrW'(WINDOW_DEPTH) + AddrW'(slot_q);
  assign raddr = AddrW'(m_q) * AddrW'(WINDOW_DEPTH) + AddrW'(idx_q[SlotW-1:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= sat_val;
    end
    rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pt_q <= '0;
      thr_q <= '0;
      interval_q <= 16'd1000;
      start_ms_q <= '0;
      prev_ms_q <= '0;
      start_seq_q <= '0;
      byte_q <= '0;
      pkt_q <= '0;
      frame_q <= '0;
      drop_q <= '0;
      slot_q <= '0;
      fill_q <= '0;
      m_q <= '0;
      avg_phase_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_PAYLOAD_TYPE: pt_q <= cfg_data_i[6:0];
          REG_DROPOUT_THR:  thr_q <= cfg_data_i;
          REG_INTERVAL:     interval_q <= cfg_data_i;
          REG_UNUSED:       ;
          default:          ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            start_ms_q <= start_d;
            start_seq_q <= start_seq_d;
            byte_q <= byte_d;
            pkt_q <= sat_inc32(pkt_q);
            if (in_tb[7]) frame_q <= sat_inc32(frame_q);
            if (gap > {16'd0, thr_q}) drop_q <= sat_inc32(drop_q);
            prev_ms_q <= in_now;
            if (elapsed_d > {16'd0, interval_q}) begin
              elapsed_q <= elapsed_d;
              expected_q <= {1'b0, in_seq - start_seq_d} + 17'd1;
              m_q <= '0;
              avg_phase_q <= 1'b0;
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          num_q <= mul_a * mul_b;
          den_q <= den_sel;
          neg_q <= neg_sel;
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= q_bit ? rem_sub : rem_sh;
          num_q <= {num_q[DivW-2:0], q_bit};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DivW - 1)) state_q <= ST_SAT;
        end
        ST_SAT: begin
          if (avg_phase_q) begin
            metric_q <= m_q;
            out_q.latest <= val_q[m_q];
            out_q.minimum <= lo_q;
            out_q.maximum <= hi_q;
            out_q.average <= sat_val;
            out_q.dropout_count <= drop_q;
            last_q <= (m_q == 2'(NumMetrics - 1));
            state_q <= ST_OUT;
          end else begin
            val_q[m_q] <= sat_val;
            if (m_q == 2'(NumMetrics - 1)) begin
              slot_q <= (slot_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
              if (fill_q != FillW'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
              byte_q <= '0;
              pkt_q <= '0;
              frame_q <= '0;
              m_q <= '0;
              avg_phase_q <= 1'b1;
              idx_q <= '0;
              sum_q <= '0;
              lo_q <= MetricMax;
              hi_q <= MetricMin;
              state_q <= ST_WALK;
            end else begin
              m_q <= m_q + 2'd1;
              state_q <= ST_PREP;
            end
          end
        end
        ST_WALK: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          sum_q <= sum_q + SumW'(rd_val);
          if (rd_val < lo_q) lo_q <= rd_val;
          if (rd_val > hi_q) hi_q <= rd_val;
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == fill_q) state_q <= ST_AVG;
          else state_q <= ST_WALK;
        end
        ST_AVG: begin
          num_q <= DivW'(sum_mag);
          den_q <= DenW'(fill_q);
          neg_q <= sum_q[SumW-1];
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= ST_DIV;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (last_q) begin
              avg_phase_q <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              m_q <= m_q + 2'd1;
              idx_q <= '0;
              sum_q <= '0;
              lo_q <= MetricMax;
              hi_q <= MetricMin;
              state_q <= ST_WALK;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {4'b0000, out_q};
  assign m_axis_tuser = metric_q;
  assign m_axis_tlast = last_q;

endmodule

// ----- sv/rtps_checker.sv -----
`timescale 1ns / 1ps
module rtps_checker import rtps_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  logic signed [MetricW-1:0] mn, mx, av;
  assign mn = $signed(m_axis_tdata[49:25]);
  assign mx = $signed(m_axis_tdata[74:50]);
  assign av = $signed(m_axis_tdata[99:75]);

  // results wait without being dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no new packet taken while results are pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready during output");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == MET_FRAME_RATE)))
    else $error("tlast not on the final metric");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (mn <= av) && (av <= mx))
    else $error("window statistics out of order");

endmodule

bind rtp_receive_statistics rtps_checker u_rtps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
